[hw/rtl/unit_registration_affiliation_table_unit_assert.svh]
// Assertion macros shared by the registration table RTL.
// Each macro expands to one labeled concurrent assertion on the clock that it is given.
`ifndef UNIT_REGISTRATION_AFFILIATION_TABLE_UNIT_ASSERT_SVH
`define UNIT_REGISTRATION_AFFILIATION_TABLE_UNIT_ASSERT_SVH

// Implication checked at every edge outside reset.
`define URAT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define URAT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/urat_pkg.sv]
// Package for the unit registration and affiliation table.
// Holds command and result codes, sizes and the output item type; no dependencies.
`timescale 1ns / 1ps

package urat_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_W = 24;
    localparam logic [15:0] TIMEOUT_RESET = 16'd43200;
    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    localparam logic [3:0] CMD_REG      = 4'd0;
    localparam logic [3:0] CMD_DEREG    = 4'd1;
    localparam logic [3:0] CMD_TOUCH    = 4'd2;
    localparam logic [3:0] CMD_QUERY    = 4'd3;
    localparam logic [3:0] CMD_AFF      = 4'd4;
    localparam logic [3:0] CMD_UNAFF    = 4'd5;
    localparam logic [3:0] CMD_IS_AFF   = 4'd6;
    localparam logic [3:0] CMD_HAS_MEM  = 4'd7;
    localparam logic [3:0] CMD_CLR_GRP  = 4'd8;
    localparam logic [3:0] CMD_CLR_REGS = 4'd9;
    localparam logic [3:0] CMD_TICK     = 4'd10;

    localparam logic [1:0] KIND_ANSWER  = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_DEREG   = 2'd2;

    localparam logic [0:0] ADDR_TIMEOUT = 1'b0;
    localparam logic [0:0] ADDR_AGING   = 1'b1;

    typedef struct packed {
        logic        last;
        logic        table_full;
        logic [31:0] timer_ms;
        logic        automatic_res;
        logic [23:0] talkgroup_id;
        logic [23:0] unit_id;
        logic        ok;
        logic [1:0]  result_kind;
    } res_t;

endpackage

[hw/rtl/urat_out_buf.sv]
// Two-entry skid buffer for result items.
// Depends on urat_pkg for the result item type.
`timescale 1ns / 1ps

module urat_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  urat_pkg::res_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output urat_pkg::res_t  out_data
);
    urat_pkg::res_t d0_reg, d1_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = d0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            priority case ({in_valid && in_ready, out_valid && out_ready})
                2'b10: cnt_reg <= cnt_reg + 2'd1;
                2'b01: cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid && out_ready) begin
            if (in_valid && in_ready && cnt_reg == 2'd1) begin
                d0_reg <= in_data;
            end else begin
                d0_reg <= d1_reg;
            end
            if (in_valid && in_ready && cnt_reg == 2'd2) begin
                d1_reg <= in_data;
            end
        end else if (in_valid && in_ready) begin
            if (cnt_reg == 2'd0) begin
                d0_reg <= in_data;
            end else begin
                d1_reg <= in_data;
            end
        end
    end
endmodule

[hw/rtl/unit_registration_affiliation_table_unit.sv]
// Top level of the unit registration and affiliation table.
// Depends on urat_pkg, urat_out_buf and the assertion macro header.
//
//  channel   | direction | contents
//  s_axis    | in        | command item: tuser = cmd; tdata = source_id, group_id,
//            |           |   release_all, automatic_in, elapsed_ms
//  m_axis    | out       | result item: tuser = result_kind; tdata = ok, unit_id,
//            |           |   talkgroup_id, automatic_res, timer_ms, table_full; tlast = last
//  apb       | in        | reg 0 timeout seconds at 0x0, reg 1 aging enable at 0x4
//
// Every command makes one pass over the table memory, one entry per cycle unless stalled, with
// each read registered ahead of its evaluation; the next item is accepted only after the pass ends.
// Reset clears the flag vectors at once; memory words are only read behind a set flag.
// A release or timeout event waits in a pending register so the last one can carry tlast;
// the scan stalls only while a newer event finds the result buffer full, and the final
// cycle waits for the buffer to take the closing item.
`timescale 1ns / 1ps
`include "unit_registration_affiliation_table_unit_assert.svh"

module unit_registration_affiliation_table_unit #(
    parameter int TABLE_DEPTH = urat_pkg::TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // source_id[23:0], group_id[47:24], release_all[48], automatic_in[49],
    // elapsed_ms[65:50], zero fill
    input  logic [71:0] s_axis_tdata,
    // cmd[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok[0], unit_id[24:1], talkgroup_id[48:25], automatic_res[49], timer_ms[81:50],
    // table_full[82], zero fill
    output logic [87:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW:0] END_IDX = TABLE_DEPTH[AW:0];
    localparam logic [AW:0] IDX_ONE = {{AW{1'b0}}, 1'b1};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // configuration
    logic [15:0] timeout_reg;
    logic        aging_reg;
    logic [31:0] limit_reg;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= urat_pkg::TIMEOUT_RESET;
            aging_reg   <= 1'b1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == urat_pkg::ADDR_TIMEOUT && paddr[1:0] == 2'b00) begin
                timeout_reg <= pwdata[15:0];
            end else if (paddr[2] == urat_pkg::ADDR_AGING && paddr[1:0] == 2'b00) begin
                aging_reg <= pwdata[0];
            end
        end
    end
    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == urat_pkg::ADDR_TIMEOUT) begin
                prdata = {16'd0, timeout_reg};
            end else begin
                prdata = {31'd0, aging_reg};
            end
        end
    end

    // command latch
    logic [3:0]  cmd_reg;
    logic [23:0] src_reg, grp_reg;
    logic [15:0] ms_reg;
    logic        rel_reg, auto_reg;

    // table: flags in flops, payload in memories
    logic [TABLE_DEPTH-1:0] regd_reg, affd_reg;
    logic [23:0] unit_mem [TABLE_DEPTH];
    logic [23:0] grp_mem  [TABLE_DEPTH];
    logic [31:0] age_mem  [TABLE_DEPTH];
    logic [23:0] rd_unit_reg, rd_grp_reg;
    logic [31:0] rd_age_reg;

    logic [1:0]    state_reg;
    logic [AW:0]   ridx_reg;       // read address, one ahead of the evaluated entry
    logic [AW-1:0] eidx_reg;       // entry whose read data is valid
    logic          evalid_reg;
    logic          found_reg, free_ok_reg, any_reg;
    logic [AW-1:0] hit_reg, free_reg;
    logic [23:0]   hit_grp_reg;
    logic [31:0]   hit_age_reg;
    urat_pkg::res_t pend_reg;
    logic           pend_v_reg;

    // write port
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          wr_unit, wr_grp, wr_age;
    logic [31:0]   mem_wdt;

    logic stall;

    always_ff @(posedge aclk) begin
        if (mem_we && wr_unit) unit_mem[mem_wa] <= src_reg;
        if (mem_we && wr_grp)  grp_mem[mem_wa]  <= grp_reg;
        if (mem_we && wr_age)  age_mem[mem_wa]  <= mem_wdt;
        // The read data holds while the scan stalls.
        if (!stall) begin
            rd_unit_reg <= unit_mem[ridx_reg[AW-1:0]];
            rd_grp_reg  <= grp_mem[ridx_reg[AW-1:0]];
            rd_age_reg  <= age_mem[ridx_reg[AW-1:0]];
        end
    end

    // result path
    urat_pkg::res_t buf_in, ob_data;
    logic           buf_v, res_ready;
    urat_out_buf u_ob (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(buf_v), .in_ready(res_ready), .in_data(buf_in),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(ob_data)
    );
    assign m_axis_tdata = {5'd0, ob_data.table_full, ob_data.timer_ms,
                           ob_data.automatic_res, ob_data.talkgroup_id,
                           ob_data.unit_id, ob_data.ok};
    assign m_axis_tuser = ob_data.result_kind;
    assign m_axis_tlast = ob_data.last;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // per-entry evaluation during the scan
    logic        e_reg, e_aff, e_used, e_match;
    logic [31:0] e_sum;
    logic        e_sat;
    logic [31:0] e_age;
    logic        e_exp;
    always_comb begin
        e_reg   = regd_reg[eidx_reg];
        e_aff   = affd_reg[eidx_reg];
        e_used  = e_reg || e_aff;
        e_match = e_used && (rd_unit_reg == src_reg);
        {e_sat, e_sum} = {1'b0, rd_age_reg} + {17'd0, ms_reg};
        e_age   = e_sat ? 32'hFFFF_FFFF : e_sum;
        e_exp   = (limit_reg != 32'd0) && (e_age >= limit_reg);
    end

    logic is_scan_cmd;
    assign is_scan_cmd = (cmd_reg == urat_pkg::CMD_CLR_GRP) ||
                         (cmd_reg == urat_pkg::CMD_TICK);

    // release and timeout events found at the evaluated entry
    urat_pkg::res_t scan_res;
    logic           scan_hit;
    always_comb begin
        scan_res = '0;
        scan_hit = 1'b0;
        if (state_reg == ST_SCAN && evalid_reg) begin
            if (cmd_reg == urat_pkg::CMD_CLR_GRP && e_aff && (grp_reg != 24'd0 || rel_reg)
                    && (grp_reg == 24'd0 || rd_grp_reg == grp_reg)) begin
                scan_hit = 1'b1;
                scan_res.result_kind = urat_pkg::KIND_RELEASE;
                scan_res.ok = 1'b1;
                scan_res.unit_id = rd_unit_reg;
                scan_res.talkgroup_id = rd_grp_reg;
            end else if (cmd_reg == urat_pkg::CMD_TICK && aging_reg && e_reg && e_exp) begin
                scan_hit = 1'b1;
                scan_res.result_kind = urat_pkg::KIND_DEREG;
                scan_res.ok = 1'b1;
                scan_res.unit_id = rd_unit_reg;
                scan_res.talkgroup_id = e_aff ? rd_grp_reg : 24'd0;
                scan_res.automatic_res = 1'b1;
            end
        end
    end
    assign stall = scan_hit && pend_v_reg && !res_ready;

    // closing answer of the command
    urat_pkg::res_t ans;
    always_comb begin
        ans = '0;
        ans.last = 1'b1;
        ans.unit_id = src_reg;
        unique case (cmd_reg)
            urat_pkg::CMD_REG: begin
                if (found_reg || free_ok_reg) begin
                    ans.ok = 1'b1;
                end else begin
                    ans.table_full = 1'b1;
                end
            end
            urat_pkg::CMD_DEREG: begin
                if (found_reg && regd_reg[hit_reg]) begin
                    ans.result_kind = urat_pkg::KIND_DEREG;
                    ans.ok = 1'b1;
                    ans.talkgroup_id = affd_reg[hit_reg] ? hit_grp_reg : 24'd0;
                    ans.automatic_res = auto_reg;
                end
            end
            urat_pkg::CMD_TOUCH:
                ans.ok = found_reg && regd_reg[hit_reg] && src_reg != 24'd0;
            urat_pkg::CMD_QUERY: begin
                ans.ok = found_reg && regd_reg[hit_reg];
                ans.timer_ms = (ans.ok && src_reg != 24'd0) ? hit_age_reg : 32'd0;
            end
            urat_pkg::CMD_AFF: begin
                ans.ok = found_reg || free_ok_reg;
                ans.table_full = !ans.ok;
            end
            urat_pkg::CMD_UNAFF: begin
                ans.ok = found_reg && affd_reg[hit_reg];
                ans.talkgroup_id = ans.ok ? hit_grp_reg : 24'd0;
            end
            urat_pkg::CMD_IS_AFF:
                ans.ok = found_reg && affd_reg[hit_reg] && hit_grp_reg == grp_reg;
            urat_pkg::CMD_HAS_MEM: begin
                ans.ok = any_reg;
                ans.unit_id = 24'd0;
            end
            urat_pkg::CMD_CLR_REGS: begin
                ans.ok = 1'b1;
                ans.unit_id = 24'd0;
            end
            urat_pkg::CMD_TICK: begin
                ans.ok = 1'b1;
                ans.unit_id = 24'd0;
            end
            default: ans.unit_id = 24'd0;
        endcase
    end

    // A pending event leaves when a newer one replaces it, or closes the pass with tlast.
    always_comb begin
        buf_in = pend_reg;
        buf_v  = 1'b0;
        if (state_reg == ST_SCAN) begin
            buf_v = scan_hit && pend_v_reg;
        end else if (state_reg == ST_FIN) begin
            buf_v = 1'b1;
            if (is_scan_cmd && pend_v_reg) begin
                buf_in.last = 1'b1;
            end else begin
                buf_in = ans;
            end
        end
    end

    // memory writes: tick age write-back during the scan, one update at the end
    always_comb begin
        mem_we = 1'b0; mem_wa = eidx_reg; wr_unit = 1'b0; wr_grp = 1'b0; wr_age = 1'b0;
        mem_wdt = e_age;
        if (state_reg == ST_SCAN) begin
            if (evalid_reg && !stall && cmd_reg == urat_pkg::CMD_TICK && aging_reg
                    && e_reg) begin
                mem_we = 1'b1;
                wr_age = 1'b1;
            end
        end else if (state_reg == ST_FIN && res_ready) begin
            mem_wdt = 32'd0;
            mem_wa  = found_reg ? hit_reg : free_reg;
            unique case (cmd_reg)
                urat_pkg::CMD_REG: begin
                    if (!(found_reg && regd_reg[hit_reg]) && (found_reg || free_ok_reg)) begin
                        mem_we = 1'b1; wr_age = 1'b1; wr_unit = !found_reg;
                    end
                end
                urat_pkg::CMD_TOUCH: begin
                    mem_we = found_reg && regd_reg[hit_reg] && src_reg != 24'd0;
                    wr_age = 1'b1;
                end
                urat_pkg::CMD_AFF: begin
                    mem_we = found_reg || free_ok_reg; wr_grp = 1'b1; wr_unit = !found_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            regd_reg   <= '0;
            affd_reg   <= '0;
            evalid_reg <= 1'b0;
            pend_v_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        state_reg   <= ST_SCAN;
                        ridx_reg    <= '0;
                        evalid_reg  <= 1'b0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        any_reg     <= 1'b0;
                        pend_v_reg  <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (!stall) begin
                        if (evalid_reg) begin
                            if (e_match && !found_reg) begin
                                found_reg   <= 1'b1;
                                hit_reg     <= eidx_reg;
                                hit_grp_reg <= rd_grp_reg;
                                hit_age_reg <= rd_age_reg;
                            end
                            if (!e_used && !free_ok_reg) begin
                                free_ok_reg <= 1'b1;
                                free_reg    <= eidx_reg;
                            end
                            if (cmd_reg == urat_pkg::CMD_HAS_MEM && e_aff
                                    && rd_grp_reg == grp_reg) begin
                                any_reg <= 1'b1;
                            end
                            if (cmd_reg == urat_pkg::CMD_CLR_REGS) begin
                                regd_reg[eidx_reg] <= 1'b0;
                            end
                            if (scan_hit) begin
                                pend_reg   <= scan_res;
                                pend_v_reg <= 1'b1;
                                affd_reg[eidx_reg] <= 1'b0;
                                if (cmd_reg == urat_pkg::CMD_TICK) begin
                                    regd_reg[eidx_reg] <= 1'b0;
                                end
                            end
                        end
                        if (ridx_reg == END_IDX) begin
                            evalid_reg <= 1'b0;
                            state_reg  <= ST_FIN;
                        end else begin
                            eidx_reg   <= ridx_reg[AW-1:0];
                            evalid_reg <= 1'b1;
                            ridx_reg   <= ridx_reg + IDX_ONE;
                        end
                    end
                end
                ST_FIN: begin
                    if (res_ready) begin
                        state_reg  <= ST_IDLE;
                        pend_v_reg <= 1'b0;
                        unique case (cmd_reg)
                            urat_pkg::CMD_REG: begin
                                if (found_reg) regd_reg[hit_reg] <= 1'b1;
                                else if (free_ok_reg) regd_reg[free_reg] <= 1'b1;
                            end
                            urat_pkg::CMD_DEREG: begin
                                if (found_reg && regd_reg[hit_reg]) begin
                                    regd_reg[hit_reg] <= 1'b0;
                                    affd_reg[hit_reg] <= 1'b0;
                                end
                            end
                            urat_pkg::CMD_AFF: begin
                                if (found_reg) affd_reg[hit_reg] <= 1'b1;
                                else if (free_ok_reg) affd_reg[free_reg] <= 1'b1;
                            end
                            urat_pkg::CMD_UNAFF: begin
                                if (found_reg) affd_reg[hit_reg] <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid) begin
            cmd_reg   <= s_axis_tuser;
            src_reg   <= s_axis_tdata[23:0];
            grp_reg   <= s_axis_tdata[47:24];
            rel_reg   <= s_axis_tdata[48];
            auto_reg  <= s_axis_tdata[49];
            ms_reg    <= s_axis_tdata[65:50];
            limit_reg <= 32'(timeout_reg) * 32'(urat_pkg::MS_PER_SEC);
        end
    end

    `URAT_ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_axis_tvalid && s_axis_tready,
        state_reg == ST_SCAN, "accepted item did not start a scan")
    `URAT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "waiting result item changed")
    `URAT_ASSERT_IMPL(a_no_out_idle, aclk, aresetn, state_reg == ST_IDLE, !buf_v,
        "result produced while idle")
    `URAT_ASSERT_IMPL(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE,
        !s_axis_tready, "input ready during a pass")
endmodule
